@@ rtl/wedm_pkg.sv @@
// Shared types, register codes and helpers for the weighted edit distance matcher.
package wedm_pkg;

   localparam int CHAR_W     = 8;
   localparam int COST_W     = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int OUT_DIST_W = 10;
   localparam int OUT_THR_W  = 3;

   localparam logic [OUT_DIST_W-1:0] DIST_SAT = 10'd1023;

   localparam logic [CSR_IDX_W-1:0] CSR_INSERT     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SUBSTITUTE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DELETE     = 2'd2;

   localparam logic [COST_W-1:0] INSERT_RESET     = 4'd1;
   localparam logic [COST_W-1:0] SUBSTITUTE_RESET = 4'd2;
   localparam logic [COST_W-1:0] DELETE_RESET     = 4'd3;

   typedef enum logic [1:0] {
      FUNC_REQ  = 2'd0,
      FUNC_FND  = 2'd1,
      FUNC_EVAL = 2'd2
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_ROW_PRE,
      ST_ROW_HEAD,
      ST_CELL
   } state_type;

   typedef struct packed {
      logic [1:0]        func;
      logic [CHAR_W-1:0] ch;
   } req_type;

   typedef struct packed {
      logic                  accepted;
      logic                  length_rejected;
      logic [OUT_DIST_W-1:0] distance;
      logic [OUT_THR_W-1:0]  threshold_used;
   } rsp_type;

   typedef struct packed {
      logic [COST_W-1:0] insert;
      logic [COST_W-1:0] substitute;
      logic [COST_W-1:0] delete;
   } cost_type;

   // Maps lower case ASCII letters to upper case; every other byte passes.
   function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] r;
      r = c;
      if (c inside {[8'h61:8'h7A]}) begin
         r = c - 8'd32;
      end
      return r;
   endfunction

endpackage

@@ rtl/wedm_cell.sv @@
// One cell of the distance table: the shared add and three-way minimum unit.
module wedm_cell import wedm_pkg::*; #(
   parameter int DIST_W = 10
) (
   input  cost_type          cost,
   input  logic [DIST_W-1:0] diag,
   input  logic [DIST_W-1:0] left,
   input  logic [DIST_W-1:0] up,
   input  logic [CHAR_W-1:0] rc,
   input  logic [CHAR_W-1:0] fc,
   output logic [DIST_W-1:0] cell_min
);

   localparam int SUM_W = DIST_W + 1;

   logic [SUM_W-1:0] sum_sub;
   logic [SUM_W-1:0] sum_ins;
   logic [SUM_W-1:0] sum_del;
   logic [SUM_W-1:0] min_a;
   logic [SUM_W-1:0] min_b;

   always_comb begin
      // The requested character arrives already folded.
      sum_sub = {1'b0, diag} +
                ((rc == fold_case(fc)) ? '0 : SUM_W'(cost.substitute));
      sum_ins = {1'b0, left} + SUM_W'(cost.insert);
      sum_del = {1'b0, up} + SUM_W'(cost.delete);
      min_a   = (sum_sub < sum_ins) ? sum_sub : sum_ins;
      min_b   = (min_a < sum_del) ? min_a : sum_del;
      cell_min = min_b[DIST_W-1:0];
   end

endmodule

@@ rtl/weighted_edit_distance_matcher_top.sv @@
// Top level of the weighted edit distance matcher: sequencer, stores and registers.
//
// Words enter on the command channel: a word is taken at a clock edge where start is
// high and busy is low. func 0 appends ch to the requested string, func 1 to the found
// string; each string keeps its first MAX_LEN bytes. An append gives no result, and
// func 3 is ignored.
// func 2 evaluates and clears both strings. With rlen and flen the two lengths, an
// evaluate rejected on length gives its result word on the cycle after it is taken.
// Otherwise busy is high while a single cell unit fills the distance table one cell
// per cycle: first the top row, then each of the rlen rows, which the states
// ST_ROW_PRE and ST_ROW_HEAD open by reading the row memory and writing the left edge.
// The result word appears in the first cycle that busy is low again.
// A result word is on rsp_data, marked by rsp_valid for exactly one cycle; the
// receiver cannot stall it, and the block may take the next command word meanwhile.
// Cost registers are written on the csr channel, which is always ready; the user must
// make writes only while idle, not enforced by the block. Synchronous reset returns the
// costs to 1, 2 and 3 and empties both strings; the character stores need no clearing pass.
module weighted_edit_distance_matcher_top import wedm_pkg::*; #(
   parameter int MAX_LEN = 20
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_valid,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COST_W-1:0]    csr_data
);

   localparam int CNT_W  = $clog2(MAX_LEN + 1);
   localparam int IDX_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int THR_W  = (CNT_W > OUT_THR_W) ? CNT_W : OUT_THR_W;
   localparam int DIST_W = $clog2(2 * MAX_LEN * 15 + 1);
   localparam int SAT_W  = (DIST_W > OUT_DIST_W) ? DIST_W : OUT_DIST_W;

   state_type          state_ff, state_in;
   cost_type           cost_ff, cost_in;
   logic [CNT_W-1:0]   req_cnt_ff, req_cnt_in;
   logic [CNT_W-1:0]   fnd_cnt_ff, fnd_cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [CNT_W-1:0]   rlen_ff, rlen_in;
   logic [CNT_W-1:0]   flen_ff, flen_in;
   logic [THR_W-1:0]   thr_ff, thr_in;
   logic [CNT_W-1:0]   i_ff, i_in;
   logic [CNT_W-1:0]   j_ff, j_in;
   logic [DIST_W-1:0]  acc_ff, acc_in;
   logic [DIST_W-1:0]  diag_ff, diag_in;
   logic [CHAR_W-1:0]  rc_ff, rc_in;

   logic [CHAR_W-1:0]  req_mem [MAX_LEN];
   logic [CHAR_W-1:0]  fnd_mem [MAX_LEN];
   logic [DIST_W-1:0]  row_mem [MAX_LEN + 1];
   logic [CHAR_W-1:0]  rd_req_ff;
   logic [CHAR_W-1:0]  rd_fnd_ff;
   logic [DIST_W-1:0]  rd_row_ff;

   logic               req_we, fnd_we;
   logic [IDX_W-1:0]   chr_waddr;
   logic               req_re, fnd_re, row_re, row_we;
   logic [IDX_W-1:0]   req_raddr, fnd_raddr;
   logic [CNT_W-1:0]   row_raddr, row_waddr;
   logic [DIST_W-1:0]  row_wdata;

   logic [CNT_W:0]     rlen_p2;
   logic [THR_W-1:0]   thr_calc;
   logic [CNT_W-1:0]   len_diff;
   logic               len_reject;
   logic [CNT_W-1:0]   i_m1;
   logic [DIST_W-1:0]  head_sum;
   logic [DIST_W-1:0]  cell_min;

   function automatic rsp_type make_rsp(input logic [DIST_W-1:0] dist_val,
                                        input logic [THR_W-1:0]  thr);
      rsp_type          r;
      logic [SAT_W-1:0] dist_ext;
      dist_ext          = SAT_W'(dist_val);
      r.accepted        = (dist_val <= DIST_W'(thr));
      r.length_rejected = 1'b0;
      r.distance        = (dist_ext > SAT_W'(DIST_SAT)) ? DIST_SAT
                                                        : dist_ext[OUT_DIST_W-1:0];
      r.threshold_used  = thr[OUT_THR_W-1:0];
      return r;
   endfunction

   wedm_cell #(
      .DIST_W(DIST_W)
   ) u_cell (
      .cost    (cost_ff),
      .diag    (diag_ff),
      .left    (acc_ff),
      .up      (rd_row_ff),
      .rc      (rc_ff),
      .fc      (rd_fnd_ff),
      .cell_min(cell_min)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      rlen_p2    = {1'b0, req_cnt_ff} + (CNT_W + 1)'(2);
      thr_calc   = THR_W'(rlen_p2 >> 2) + THR_W'(1);
      len_diff   = (req_cnt_ff > fnd_cnt_ff) ? (req_cnt_ff - fnd_cnt_ff)
                                             : (fnd_cnt_ff - req_cnt_ff);
      len_reject = (THR_W'(len_diff) > thr_calc);
      i_m1       = i_ff - CNT_W'(1);
      head_sum   = rd_row_ff + DIST_W'(cost_ff.delete);
   end

   always_comb begin
      state_in     = state_ff;
      cost_in      = cost_ff;
      req_cnt_in   = req_cnt_ff;
      fnd_cnt_in   = fnd_cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      rlen_in      = rlen_ff;
      flen_in      = flen_ff;
      thr_in       = thr_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      acc_in       = acc_ff;
      diag_in      = diag_ff;
      rc_in        = rc_ff;
      req_we       = 1'b0;
      fnd_we       = 1'b0;
      chr_waddr    = '0;
      req_re       = 1'b0;
      fnd_re       = 1'b0;
      row_re       = 1'b0;
      row_we       = 1'b0;
      req_raddr    = '0;
      fnd_raddr    = '0;
      row_raddr    = '0;
      row_waddr    = '0;
      row_wdata    = '0;

      if (csr_valid) begin
         case (csr_index)
            CSR_INSERT:     cost_in.insert     = csr_data;
            CSR_SUBSTITUTE: cost_in.substitute = csr_data;
            CSR_DELETE:     cost_in.delete     = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_data.func)
                  FUNC_REQ: begin
                     if (req_cnt_ff < CNT_W'(MAX_LEN)) begin
                        req_we     = 1'b1;
                        chr_waddr  = req_cnt_ff[IDX_W-1:0];
                        req_cnt_in = req_cnt_ff + CNT_W'(1);
                     end
                  end
                  FUNC_FND: begin
                     if (fnd_cnt_ff < CNT_W'(MAX_LEN)) begin
                        fnd_we     = 1'b1;
                        chr_waddr  = fnd_cnt_ff[IDX_W-1:0];
                        fnd_cnt_in = fnd_cnt_ff + CNT_W'(1);
                     end
                  end
                  FUNC_EVAL: begin
                     rlen_in    = req_cnt_ff;
                     flen_in    = fnd_cnt_ff;
                     thr_in     = thr_calc;
                     req_cnt_in = '0;
                     fnd_cnt_in = '0;
                     if (len_reject) begin
                        rsp_valid_in           = 1'b1;
                        rsp_in.accepted        = 1'b0;
                        rsp_in.length_rejected = 1'b1;
                        rsp_in.distance        = '0;
                        rsp_in.threshold_used  = thr_calc[OUT_THR_W-1:0];
                     end else begin
                        j_in     = '0;
                        acc_in   = '0;
                        state_in = ST_INIT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_INIT: begin
            // First row: each entry is the previous one plus the insert cost.
            row_we    = 1'b1;
            row_waddr = j_ff;
            row_wdata = acc_ff;
            if (j_ff == flen_ff) begin
               if (rlen_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = make_rsp(acc_ff, thr_ff);
                  state_in     = ST_IDLE;
               end else begin
                  i_in     = CNT_W'(1);
                  state_in = ST_ROW_PRE;
               end
            end else begin
               j_in   = j_ff + CNT_W'(1);
               acc_in = acc_ff + DIST_W'(cost_ff.insert);
            end
         end
         ST_ROW_PRE: begin
            row_re    = 1'b1;
            row_raddr = '0;
            req_re    = 1'b1;
            req_raddr = i_m1[IDX_W-1:0];
            state_in  = ST_ROW_HEAD;
         end
         ST_ROW_HEAD: begin
            // Left edge of the row; the old value becomes the first diagonal.
            row_we    = 1'b1;
            row_waddr = '0;
            row_wdata = head_sum;
            acc_in    = head_sum;
            diag_in   = rd_row_ff;
            rc_in     = fold_case(rd_req_ff);
            if (flen_ff == '0) begin
               if (i_ff == rlen_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = make_rsp(head_sum, thr_ff);
                  state_in     = ST_IDLE;
               end else begin
                  i_in     = i_ff + CNT_W'(1);
                  state_in = ST_ROW_PRE;
               end
            end else begin
               row_re    = 1'b1;
               row_raddr = CNT_W'(1);
               fnd_re    = 1'b1;
               fnd_raddr = '0;
               j_in      = CNT_W'(1);
               state_in  = ST_CELL;
            end
         end
         ST_CELL: begin
            // The read for the next column is issued while this column is written.
            row_we    = 1'b1;
            row_waddr = j_ff;
            row_wdata = cell_min;
            acc_in    = cell_min;
            diag_in   = rd_row_ff;
            if (j_ff == flen_ff) begin
               if (i_ff == rlen_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = make_rsp(cell_min, thr_ff);
                  state_in     = ST_IDLE;
               end else begin
                  i_in     = i_ff + CNT_W'(1);
                  state_in = ST_ROW_PRE;
               end
            end else begin
               row_re    = 1'b1;
               row_raddr = j_ff + CNT_W'(1);
               fnd_re    = 1'b1;
               fnd_raddr = j_ff[IDX_W-1:0];
               j_in      = j_ff + CNT_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         cost_ff.insert     <= INSERT_RESET;
         cost_ff.substitute <= SUBSTITUTE_RESET;
         cost_ff.delete     <= DELETE_RESET;
         req_cnt_ff         <= '0;
         fnd_cnt_ff         <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cost_ff      <= cost_in;
         req_cnt_ff   <= req_cnt_in;
         fnd_cnt_ff   <= fnd_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      rlen_ff <= rlen_in;
      flen_ff <= flen_in;
      thr_ff  <= thr_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      acc_ff  <= acc_in;
      diag_ff <= diag_in;
      rc_ff   <= rc_in;
   end

   always_ff @(posedge clock) begin
      if (req_we) begin
         req_mem[chr_waddr] <= req_data.ch;
      end
      if (req_re) begin
         rd_req_ff <= req_mem[req_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (fnd_we) begin
         fnd_mem[chr_waddr] <= req_data.ch;
      end
      if (fnd_re) begin
         rd_fnd_ff <= fnd_mem[fnd_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (row_we) begin
         row_mem[row_waddr] <= row_wdata;
      end
      if (row_re) begin
         rd_row_ff <= row_mem[row_raddr];
      end
   end

   // Both strings are emptied when an evaluation starts, so they stay empty while busy.
   assert property (@(posedge clock) disable iff (reset)
      busy |-> (req_cnt_ff == '0) && (fnd_cnt_ff == '0))
      else $error("string count not cleared during evaluation");

   assert property (@(posedge clock) disable iff (reset)
      (req_cnt_ff <= CNT_W'(MAX_LEN)) && (fnd_cnt_ff <= CNT_W'(MAX_LEN)))
      else $error("string count beyond store depth");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CELL) |-> (j_ff != '0) && (j_ff <= flen_ff))
      else $error("cell column outside the found string");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.length_rejected) |->
         (rsp_ff.distance == '0) && !rsp_ff.accepted)
      else $error("length rejection carries a distance or an accept");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(busy || (start && (req_data.func == FUNC_EVAL))))
      else $error("result word without an evaluation");

endmodule
